>>> hdl/xtea_pkg.sv
// Shared types, constants and round helpers for the XTEA block cipher.
package xtea_pkg;

  localparam logic [31:0] DELTA          = 32'h9E3779B9;
  localparam int          KEY_SEL_SHIFT  = 11;
  localparam int          MIX_SHL        = 4;
  localparam int          MIX_SHR        = 5;
  localparam logic [7:0]  ROUNDS_RESET   = 8'd32;
  localparam logic [31:0] DEC_SUM_RESET  = 32'hC6EF3720;
  localparam int          CFG_IDX_W      = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam int          HALF_CNT_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } xtea_in_t;

  typedef struct packed {
    logic [31:0] out_first_word;
    logic [31:0] out_second_word;
  } xtea_out_t;

  typedef logic [3:0][31:0] xtea_key_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } xtea_cmd_t;

  function automatic logic [31:0] mix_word(input logic [31:0] w);
    return ((w << MIX_SHL) ^ (w >> MIX_SHR)) + w;
  endfunction

endpackage

>>> hdl/xtea_ctrl.sv
// Sequencer for the XTEA block cipher: transfer handshakes and round count.
module xtea_ctrl
  import xtea_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic [7:0]      rounds,
  output xtea_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } xtea_state_t;

  xtea_state_t           state_r, state_nxt;
  logic [HALF_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = {rounds, 1'b0};
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r != '0) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r - HALF_CNT_W'(1);
        end else if (out_free) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/xtea_dp.sv
// Datapath for the XTEA block cipher: one half round per cycle and the result register.
module xtea_dp
  import xtea_pkg::*;
(
  input  logic        clk,
  input  xtea_cmd_t   cmd,
  input  xtea_in_t    in_data,
  input  xtea_key_t   key,
  input  logic [31:0] dec_sum,
  output xtea_out_t   out_data
);

  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        dec_r, dec_nxt;
  logic        phase_r, phase_nxt;
  xtea_out_t   out_r, out_nxt;

  logic        tgt_b;
  logic [1:0]  key_idx;
  logic [31:0] src_word;
  logic [31:0] tgt_word;
  logic [31:0] f_val;
  logic [31:0] new_word;

  assign tgt_b    = phase_r ^ dec_r;
  assign key_idx  = tgt_b ? sum_r[KEY_SEL_SHIFT +: 2] : sum_r[1:0];
  assign src_word = tgt_b ? a_r : b_r;
  assign tgt_word = tgt_b ? b_r : a_r;
  assign f_val    = mix_word(src_word) ^ (sum_r + key[key_idx]);
  assign new_word = dec_r ? (tgt_word - f_val) : (tgt_word + f_val);

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    sum_nxt   = sum_r;
    dec_nxt   = dec_r;
    phase_nxt = phase_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      a_nxt     = in_data.first_word;
      b_nxt     = in_data.second_word;
      dec_nxt   = in_data.opcode;
      sum_nxt   = in_data.opcode ? dec_sum : '0;
      phase_nxt = 1'b0;
    end else if (cmd.step) begin
      if (tgt_b) begin
        b_nxt = new_word;
      end else begin
        a_nxt = new_word;
      end
      if (!phase_r) begin
        sum_nxt = dec_r ? (sum_r - DELTA) : (sum_r + DELTA);
      end
      phase_nxt = !phase_r;
    end
    if (cmd.capture) begin
      out_nxt.out_first_word  = a_r;
      out_nxt.out_second_word = b_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    sum_r   <= sum_nxt;
    dec_r   <= dec_nxt;
    phase_r <= phase_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> hdl/xtea_block_cipher.sv
// Top level of the XTEA block cipher: configuration registers, sequencer and datapath.
//
// Input channel (in_valid / in_stall / in_data): one 64-bit block as two
// 32-bit words plus an opcode, 0 encrypts and 1 decrypts. A transfer takes
// place when in_valid is high and in_stall is low.
// Result channel (out_valid / out_stall / out_data): one processed block per
// accepted input, held in an output register until the receiver transfers it.
// Configuration port (cfg_we / cfg_index / cfg_wdata): indexes 0 to 3 write
// the key words, index 4 writes the round count; other indexes are ignored.
// Write it only while no block is in flight.
// Timing: the shared round unit does one half round per cycle, two per round,
// after the block's transfer; the result register is then loaded, and a new
// block is taken only after that, so one block is processed at a time.
// A stalled result holds the round unit at its end until the output
// register frees; the input stays stalled meanwhile.
// Reset clears the handshake state, zeroes the key and sets 32 rounds.
module xtea_block_cipher
  import xtea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  xtea_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output xtea_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  xtea_key_t   key_r, key_nxt;
  logic [7:0]  rounds_r, rounds_nxt;
  logic [31:0] dec_sum_r, dec_sum_nxt;
  logic [39:0] dec_sum_prod;
  xtea_cmd_t   cmd;

  assign dec_sum_prod = 40'(DELTA) * 40'(cfg_wdata[7:0]);

  always_comb begin
    key_nxt     = key_r;
    rounds_nxt  = rounds_r;
    dec_sum_nxt = dec_sum_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0: key_nxt[0] = cfg_wdata;
        CFG_KEY1: key_nxt[1] = cfg_wdata;
        CFG_KEY2: key_nxt[2] = cfg_wdata;
        CFG_KEY3: key_nxt[3] = cfg_wdata;
        CFG_ROUNDS: begin
          rounds_nxt  = cfg_wdata[7:0];
          dec_sum_nxt = dec_sum_prod[31:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      rounds_r  <= ROUNDS_RESET;
      dec_sum_r <= DEC_SUM_RESET;
    end else begin
      key_r     <= key_nxt;
      rounds_r  <= rounds_nxt;
      dec_sum_r <= dec_sum_nxt;
    end
  end

  xtea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rounds    (rounds_r),
    .cmd       (cmd)
  );

  xtea_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .key      (key_r),
    .dec_sum  (dec_sum_r),
    .out_data (out_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the XTEA block cipher: directed and random blocks.
`timescale 1ns / 1ps

module tb;
  import xtea_pkg::*;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;
  localparam int   WATCHDOG_LIMIT = 6000;
  localparam int   HOLD_CYCLES = 300;
  localparam int   RANDOM_PHASES = 8;
  localparam int   BLOCKS_PER_PHASE = 54;

  class xtea_scoreboard;
    logic [31:0] key_words [4];
    logic [7:0]  round_cnt;
    xtea_out_t   expected_blocks [$];
    int unsigned blocks_in, blocks_out, encrypts, decrypts, mismatches;

    function new();
      key_words = '{default: '0};
      round_cnt = ROUNDS_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_words[idx[1:0]] = data;
        CFG_ROUNDS: round_cnt = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mix(logic [31:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function logic [31:0] subkey(logic [31:0] s, int shift);
      logic [1:0] sel;
      sel = 2'(s >> shift);
      return s + key_words[sel];
    endfunction

    function xtea_out_t crypt_block(xtea_in_t blk);
      logic [31:0] a, b, s;
      xtea_out_t res;
      a = blk.first_word;
      b = blk.second_word;
      if (blk.opcode == OP_ENCRYPT) begin
        s = '0;
        for (int r = 0; r < round_cnt; r++) begin
          a = a + (mix(b) ^ subkey(s, 0));
          s = s + DELTA;
          b = b + (mix(a) ^ subkey(s, KEY_SEL_SHIFT));
        end
      end else begin
        s = DELTA * {24'd0, round_cnt};
        for (int r = 0; r < round_cnt; r++) begin
          b = b - (mix(a) ^ subkey(s, KEY_SEL_SHIFT));
          s = s - DELTA;
          a = a - (mix(b) ^ subkey(s, 0));
        end
      end
      res.out_first_word = a;
      res.out_second_word = b;
      return res;
    endfunction

    function void log_block(xtea_in_t blk);
      blocks_in++;
      if (blk.opcode == OP_ENCRYPT) encrypts++;
      else decrypts++;
      expected_blocks.push_back(crypt_block(blk));
    endfunction

    function void check_block(xtea_out_t got);
      xtea_out_t want;
      blocks_out++;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h %h", got.out_first_word, got.out_second_word);
        return;
      end
      want = expected_blocks.pop_front();
      if (got.out_first_word !== want.out_first_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d out_first_word: expected %h, got %h",
                   blocks_out, want.out_first_word, got.out_first_word);
      end
      if (got.out_second_word !== want.out_second_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d out_second_word: expected %h, got %h",
                   blocks_out, want.out_second_word, got.out_second_word);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  xtea_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  xtea_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  xtea_scoreboard sb = new();
  int burst_left = 1;
  int gap_due = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;
  logic in_xfer, out_xfer;

  assign in_xfer = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always #5 clk = ~clk;

  xtea_block_cipher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && in_xfer) sb.log_block(in_data);
    if (rst_n && out_xfer) sb.check_block(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || in_xfer || out_xfer) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.expected_blocks.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern in segments, plus one long hold while blocks are offered
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.blocks_out >= 120 && in_valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = 32'd1 << $urandom_range(0, 31);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic xtea_in_t mk_block(logic op, logic [31:0] a, logic [31:0] b);
    xtea_in_t blk;
    blk.opcode = op;
    blk.first_word = a;
    blk.second_word = b;
    return blk;
  endfunction

  task automatic send_block(xtea_in_t blk);
    if (gap_due > 0) begin
      in_valid <= 1'b0;
      repeat (gap_due) @(posedge clk);
      gap_due = 0;
    end
    in_valid <= 1'b1;
    in_data <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap_due = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  // encrypt a block, then decrypt the predicted ciphertext
  task automatic send_round_trip(logic [31:0] a, logic [31:0] b);
    xtea_in_t blk;
    xtea_out_t ct;
    blk = mk_block(OP_ENCRYPT, a, b);
    ct = sb.crypt_block(blk);
    send_block(blk);
    send_block(mk_block(OP_DECRYPT, ct.out_first_word, ct.out_second_word));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                             logic [31:0] k3, logic [31:0] rounds_data);
    wait_idle();
    write_cfg(CFG_KEY0, k0);
    write_cfg(CFG_KEY1, k1);
    write_cfg(CFG_KEY2, k2);
    write_cfg(CFG_KEY3, k3);
    write_cfg(CFG_ROUNDS, rounds_data);
    write_cfg(3'(CFG_ROUNDS + $urandom_range(1, 3)), $urandom);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [31:0] rand_rounds();
    logic [31:0] data;
    data = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: data[7:0] = 8'($urandom_range(1, 12));
      6: data[7:0] = 8'd0;
      7: data[7:0] = 8'd32;
      8: data[7:0] = 8'($urandom_range(13, 40));
      default: data[7:0] = 8'($urandom_range(1, 4));
    endcase
    return data;
  endfunction

  initial begin
    int count;
    bit paused;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: zero key, 32 rounds
    send_block(mk_block(OP_ENCRYPT, '0, '0));
    send_block(mk_block(OP_DECRYPT, '0, '0));
    send_block(mk_block(OP_ENCRYPT, '1, '1));
    send_block(mk_block(OP_DECRYPT, '1, '1));
    send_block(mk_block(OP_ENCRYPT, '0, '1));
    send_block(mk_block(OP_DECRYPT, '1, '0));
    send_round_trip($urandom, $urandom);

    // zero rounds via a round count with upper bits set: pass-through
    load_config('1, '1, '1, '1, 32'hFFFFFF00);
    send_block(mk_block(OP_ENCRYPT, 32'hA5A5A5A5, 32'h5A5A5A5A));
    send_block(mk_block(OP_DECRYPT, 32'hA5A5A5A5, 32'h5A5A5A5A));
    send_block(mk_block(OP_ENCRYPT, '0, '1));
    send_block(mk_block(OP_DECRYPT, '1, '0));

    load_config($urandom, $urandom, $urandom, $urandom, 32'd1);
    send_round_trip($urandom, $urandom);
    send_block(mk_block(OP_ENCRYPT, '1, '0));
    send_block(mk_block(OP_DECRYPT, '0, '1));

    load_config(32'h80000000, 32'h7FFFFFFF, '0, '1, 32'd255);
    send_round_trip('1, '1);
    send_block(mk_block(OP_DECRYPT, '0, '0));
    send_block(mk_block(OP_ENCRYPT, '0, '0));

    paused = 1'b0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_config(rand_word(), rand_word(), rand_word(), rand_word(), rand_rounds());
      count = 0;
      while (count < BLOCKS_PER_PHASE) begin
        if (p == 3 && !paused && count >= BLOCKS_PER_PHASE / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 5) begin
          send_round_trip(rand_word(), rand_word());
          count += 2;
        end else begin
          send_block(mk_block(1'($urandom_range(0, 1)), rand_word(), rand_word()));
          count++;
        end
      end
    end

    wait_idle();
    repeat (2 * sb.round_cnt + 10) @(posedge clk);
    $display("Covered %0d blocks (%0d encrypt, %0d decrypt) over %0d key and round settings,",
             sb.blocks_in, sb.encrypts, sb.decrypts, n_settings + 1);
    $display("round counts from 0 to 255, one long receiver hold; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_blocks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/xtea_pkg.sv
hdl/xtea_ctrl.sv
hdl/xtea_dp.sv
hdl/xtea_block_cipher.sv
tb/tb.sv
